FILE: hdl/button_click_long_press_detector_assert.svh
// Assertion macros for the button click / long press detector checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset only
`define BCLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcld check failed");

// Next-cycle implication, checked out of reset only
`define BCLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcld check failed");

`endif

FILE: hdl/bcld_pkg.sv
// Shared codes for the button click / long press detector.
// No dependencies; used by the top level and the checker.
package bcld_pkg;

  // Press machine phases
  localparam logic [2:0] PH_IDLE          = 3'd0;
  localparam logic [2:0] PH_PRESSED       = 3'd1;
  localparam logic [2:0] PH_RELEASED      = 3'd2;
  localparam logic [2:0] PH_LONG_PRESSING = 3'd3;
  localparam logic [2:0] PH_LONG_PRESSED  = 3'd4;
  localparam logic [2:0] PH_ADJUST        = 3'd5;

  // Reported events
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  // Click tally values
  localparam logic [1:0] TALLY_NONE   = 2'd0;
  localparam logic [1:0] TALLY_ONE    = 2'd1;
  localparam logic [1:0] TALLY_DOUBLE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [2:0] REG_DCLICK_GAP  = 3'd2;
  localparam logic [2:0] REG_CLICK_TMO   = 3'd3;
  localparam logic [2:0] REG_ADJUST_TMO  = 3'd4;

  // Configuration reset values
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [15:0] DCLICK_GAP_RST = 16'd300;
  localparam logic [15:0] CLICK_TMO_RST  = 16'd400;
  localparam logic [15:0] ADJUST_TMO_RST = 16'd5000;

endpackage

FILE: hdl/bcld_in_if.sv
// Poll channel: timestamp and raw button level, valid/ready handshake.
// No dependencies.
interface bcld_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        raw_level;

  modport source (output valid, output now_ms, output raw_level, input ready);
  modport sink   (input valid, input now_ms, input raw_level, output ready);
endinterface

FILE: hdl/bcld_out_if.sv
// Result channel: event, debounced level, phase and press duration.
// No dependencies.
interface bcld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_code;
  logic        pressed_level;
  logic        adjust_mode;
  logic [2:0]  phase;
  logic [31:0] press_duration_ms;

  modport source (output valid, output event_code, output pressed_level,
                  output adjust_mode, output phase, output press_duration_ms,
                  input ready);
  modport sink   (input valid, input event_code, input pressed_level,
                  input adjust_mode, input phase, input press_duration_ms,
                  output ready);
endinterface

FILE: hdl/button_click_long_press_detector.sv
// Button debounce and click / double click / long press detector, top level.
// Depends on bcld_pkg, bcld_in_if and bcld_out_if.
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------------------
//   in_ch    | in  | now_ms[31:0], raw_level
//   out_ch   | out | event_code[1:0], pressed_level, adjust_mode, phase[2:0],
//            |     | press_duration_ms[31:0]
//   cfg      | in  | cfg_we_i, cfg_idx_i[2:0], cfg_wdata_i[15:0]
//
// One beat per cycle while the result is taken; a poll passes the input register,
// then the subtract/compare logic into the result register, which also updates
// the debounce and press state.
// Reset returns all state to idle and the registers to their defaults.
// A stalled result holds the result register; the input register still
// takes one more beat, then input ready drops until the result moves.
module button_click_long_press_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcld_in_if.sink     in_ch,
  bcld_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import bcld_pkg::*;

  // Configuration registers
  logic [15:0] debounce_q, long_press_q, dclick_gap_q, click_tmo_q, adjust_tmo_q;

  // Input stage
  logic        in_vld_q;
  logic [31:0] in_now_q;
  logic        in_raw_q;
  logic        advance;

  // Detector state
  logic [2:0]  phase_q, phase_d;
  logic        prev_raw_q;
  logic        deb_q, deb_d;
  logic [31:0] last_chg_q, last_chg_d;
  logic [31:0] press_start_q, press_start_d;
  logic [31:0] release_q, release_d;
  logic [1:0]  tally_q, tally_d;
  logic [31:0] adjust_start_q, adjust_start_d;

  // Result stage
  logic        out_vld_q;
  logic [1:0]  ev_q, ev_d;
  logic        lvl_q;
  logic [2:0]  out_phase_q;
  logic [31:0] dur_q, dur_d;

  // Elapsed times
  logic [31:0] stable_ms, held_ms, gap_ms, adj_ms;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_press_q <= LONG_PRESS_RST;
      dclick_gap_q <= DCLICK_GAP_RST;
      click_tmo_q  <= CLICK_TMO_RST;
      adjust_tmo_q <= ADJUST_TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        REG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        REG_DCLICK_GAP: dclick_gap_q <= cfg_wdata_i;
        REG_CLICK_TMO:  click_tmo_q  <= cfg_wdata_i;
        REG_ADJUST_TMO: adjust_tmo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Move the held poll on when the result register is free or draining
  assign advance     = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_now_q <= in_ch.now_ms;
      in_raw_q <= in_ch.raw_level;
    end
  end

  // Debounce: accept the raw level once it is stable longer than the threshold
  assign last_chg_d = (in_raw_q != prev_raw_q) ? in_now_q : last_chg_q;
  assign stable_ms  = in_now_q - last_chg_d;
  assign deb_d      = (stable_ms > {16'd0, debounce_q}) ? in_raw_q : deb_q;

  assign held_ms = in_now_q - press_start_q;
  assign gap_ms  = in_now_q - release_q;
  assign adj_ms  = in_now_q - adjust_start_q;

  // Press machine
  always_comb begin
    phase_d        = phase_q;
    press_start_d  = press_start_q;
    release_d      = release_q;
    tally_d        = tally_q;
    adjust_start_d = adjust_start_q;
    ev_d           = EV_NONE;
    case (phase_q)
      PH_IDLE: begin
        if (deb_d) begin
          press_start_d = in_now_q;
          tally_d       = TALLY_ONE;
          phase_d       = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!deb_d) begin
          release_d = in_now_q;
          phase_d   = PH_RELEASED;
        end else if (held_ms >= {16'd0, long_press_q}) begin
          ev_d           = EV_LONG;
          phase_d        = PH_LONG_PRESSED;
          adjust_start_d = in_now_q;
        end
      end
      PH_RELEASED: begin
        if (deb_d) begin
          tally_d       = (gap_ms <= {16'd0, dclick_gap_q}) ? TALLY_DOUBLE : TALLY_ONE;
          press_start_d = in_now_q;
          phase_d       = PH_PRESSED;
        end else if (gap_ms > {16'd0, click_tmo_q}) begin
          ev_d    = (tally_q == TALLY_DOUBLE) ? EV_DOUBLE : EV_SINGLE;
          tally_d = TALLY_NONE;
          phase_d = PH_IDLE;
        end
      end
      PH_LONG_PRESSING: begin
        if (!deb_d) begin
          phase_d = PH_IDLE;
        end
      end
      PH_LONG_PRESSED: begin
        if (!deb_d) begin
          phase_d        = PH_ADJUST;
          adjust_start_d = in_now_q;
        end
      end
      PH_ADJUST: begin
        // timeout wins over a press
        if (adj_ms >= {16'd0, adjust_tmo_q}) begin
          phase_d = PH_IDLE;
          tally_d = TALLY_NONE;
        end else if (deb_d) begin
          press_start_d = in_now_q;
          phase_d       = PH_PRESSED;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Report hold time only while the button counts as held
  assign dur_d = (phase_d == PH_PRESSED || phase_d == PH_LONG_PRESSING) ?
                 (in_now_q - press_start_d) : 32'd0;

  // Update state on each processed poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      prev_raw_q     <= 1'b0;
      deb_q          <= 1'b0;
      last_chg_q     <= 32'd0;
      press_start_q  <= 32'd0;
      release_q      <= 32'd0;
      tally_q        <= TALLY_NONE;
      adjust_start_q <= 32'd0;
    end else if (advance) begin
      phase_q        <= phase_d;
      prev_raw_q     <= in_raw_q;
      deb_q          <= deb_d;
      last_chg_q     <= last_chg_d;
      press_start_q  <= press_start_d;
      release_q      <= release_d;
      tally_q        <= tally_d;
      adjust_start_q <= adjust_start_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q        <= ev_d;
      lvl_q       <= deb_d;
      out_phase_q <= phase_d;
      dur_q       <= dur_d;
    end
  end

  assign out_ch.valid             = out_vld_q;
  assign out_ch.event_code        = ev_q;
  assign out_ch.pressed_level     = lvl_q;
  assign out_ch.adjust_mode       = (out_phase_q == PH_ADJUST);
  assign out_ch.phase             = out_phase_q;
  assign out_ch.press_duration_ms = dur_q;

endmodule

FILE: hdl/bcld_chk.sv
// Port-level checker for the button click / long press detector, and its bind.
// Depends on bcld_pkg and button_click_long_press_detector_assert.svh.
`include "button_click_long_press_detector_assert.svh"

module bcld_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_code,
  input logic        pressed_level,
  input logic        adjust_mode,
  input logic [2:0]  phase,
  input logic [31:0] press_duration_ms
);
  import bcld_pkg::*;

  // Adjust flag mirrors the adjust phase
  `BCLD_ASSERT_NOW(a_adjust_flag, out_valid, adjust_mode == (phase == PH_ADJUST))

  // A hold time shows only in a held phase
  `BCLD_ASSERT_NOW(a_dur_phase, out_valid && press_duration_ms != 32'd0,
    phase == PH_PRESSED || phase == PH_LONG_PRESSING)

  // A long press lands in the long pressed phase with the button down
  `BCLD_ASSERT_NOW(a_long_phase, out_valid && event_code == EV_LONG,
    phase == PH_LONG_PRESSED && pressed_level)

  // A click report returns to idle with the button up
  `BCLD_ASSERT_NOW(a_click_idle,
    out_valid && (event_code == EV_SINGLE || event_code == EV_DOUBLE),
    phase == PH_IDLE && !pressed_level)

  // A stalled result beat holds
  `BCLD_ASSERT_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(event_code) && $stable(phase) && $stable(press_duration_ms))

endmodule

bind button_click_long_press_detector bcld_chk u_bcld_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .event_code        (out_ch.event_code),
  .pressed_level     (out_ch.pressed_level),
  .adjust_mode       (out_ch.adjust_mode),
  .phase             (out_ch.phase),
  .press_duration_ms (out_ch.press_duration_ms)
);

FILE: tb/sv/tb_top.sv
// Self-checking bench for the button click / long press detector.
// Depends on bcld_pkg, bcld_in_if, bcld_out_if and the detector top level.
// Polls go through a handshake-driven sender; a bit-true predictor checks every result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcld_pkg::*;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned REPORT_CAP   = 200;
  localparam int unsigned CFG_IDX_SPAN = 8;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [1:0]  event_code;
    logic        pressed_level;
    logic        adjust_mode;
    logic [2:0]  phase;
    logic [31:0] press_duration_ms;
  } poll_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  bcld_in_if  in_ch ();
  bcld_out_if out_ch ();

  button_click_long_press_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor copy of the thresholds
  logic [15:0] cfg_debounce   = DEBOUNCE_RST;
  logic [15:0] cfg_long_press = LONG_PRESS_RST;
  logic [15:0] cfg_dclick_gap = DCLICK_GAP_RST;
  logic [15:0] cfg_click_tmo  = CLICK_TMO_RST;
  logic [15:0] cfg_adjust_tmo = ADJUST_TMO_RST;

  // Predictor copy of the debounce and press state
  logic [2:0]  pr_phase      = PH_IDLE;
  logic        pr_prev_raw   = 1'b0;
  logic        pr_level      = 1'b0;
  logic [31:0] pr_last_edge  = '0;
  logic [31:0] pr_press_t0   = '0;
  logic [31:0] pr_release_t0 = '0;
  logic [1:0]  pr_tally      = TALLY_NONE;
  logic [31:0] pr_adjust_t0  = '0;

  poll_result_t pending_results[$];
  poll_result_t oldest_result;
  int unsigned  mismatches   = 0;
  int unsigned  polls_sent   = 0;
  int unsigned  stall_cycles = 0;
  bit           quiet_run    = 1'b0;
  logic [31:0]  poll_clock   = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the predicted state by one poll and return the result it gives
  function automatic poll_result_t predict_poll_result(logic [31:0] now, logic raw);
    poll_result_t r;
    logic [31:0]  dt;
    logic         down;
    r = '0;
    r.event_code = EV_NONE;
    if (raw != pr_prev_raw) pr_last_edge = now;
    dt = now - pr_last_edge;
    if (dt > {16'd0, cfg_debounce}) pr_level = raw;
    pr_prev_raw = raw;
    down = pr_level;
    case (pr_phase)
      PH_IDLE: begin
        if (down) begin
          pr_press_t0 = now;
          pr_tally    = TALLY_ONE;
          pr_phase    = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        dt = now - pr_press_t0;
        if (!down) begin
          pr_release_t0 = now;
          pr_phase      = PH_RELEASED;
        end else if (dt >= {16'd0, cfg_long_press}) begin
          r.event_code = EV_LONG;
          pr_phase     = PH_LONG_PRESSED;
          pr_adjust_t0 = now;
        end
      end
      PH_RELEASED: begin
        dt = now - pr_release_t0;
        if (down) begin
          pr_tally    = (dt <= {16'd0, cfg_dclick_gap}) ? TALLY_DOUBLE : TALLY_ONE;
          pr_press_t0 = now;
          pr_phase    = PH_PRESSED;
        end else if (dt > {16'd0, cfg_click_tmo}) begin
          r.event_code = (pr_tally == TALLY_DOUBLE) ? EV_DOUBLE : EV_SINGLE;
          pr_tally     = TALLY_NONE;
          pr_phase     = PH_IDLE;
        end
      end
      PH_LONG_PRESSING: begin
        if (!down) pr_phase = PH_IDLE;
      end
      PH_LONG_PRESSED: begin
        if (!down) begin
          pr_phase     = PH_ADJUST;
          pr_adjust_t0 = now;
        end
      end
      PH_ADJUST: begin
        // timeout wins over the button
        dt = now - pr_adjust_t0;
        if (dt >= {16'd0, cfg_adjust_tmo}) begin
          pr_phase = PH_IDLE;
          pr_tally = TALLY_NONE;
        end else if (down) begin
          pr_press_t0 = now;
          pr_phase    = PH_PRESSED;
        end
      end
      default: pr_phase = PH_IDLE;
    endcase
    if (pr_phase == PH_PRESSED || pr_phase == PH_LONG_PRESSING)
      r.press_duration_ms = now - pr_press_t0;
    r.pressed_level = pr_level;
    r.adjust_mode   = (pr_phase == PH_ADJUST);
    r.phase         = pr_phase;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      // keep the log short when the block is badly off
      if (mismatches <= REPORT_CAP)
        $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Drive result ready and check every result beat against the oldest expectation
  always @(posedge clk_i) begin
    out_ch.ready <= quiet_run || ($urandom_range(99) >= 9);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t ns: result expected none actual phase %0h event %0h", $time,
                   out_ch.phase, out_ch.event_code);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("event_code", 32'(oldest_result.event_code),
                    32'(out_ch.event_code));
        check_field("pressed_level", 32'(oldest_result.pressed_level),
                    32'(out_ch.pressed_level));
        check_field("adjust_mode", 32'(oldest_result.adjust_mode),
                    32'(out_ch.adjust_mode));
        check_field("phase", 32'(oldest_result.phase), 32'(out_ch.phase));
        check_field("press_duration_ms", oldest_result.press_duration_ms,
                    out_ch.press_duration_ms);
      end
    end
  end

  // Count cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one poll: random idle first, then hold valid until the beat is taken
  task automatic send_poll(input logic [31:0] now, input logic raw);
    if (!quiet_run) begin
      while ($urandom_range(99) < 9) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.now_ms    <= now;
    in_ch.raw_level <= raw;
    pending_results.push_back(predict_poll_result(now, raw));
    polls_sent++;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_DEBOUNCE:   cfg_debounce   = data;
      REG_LONG_PRESS: cfg_long_press = data;
      REG_DCLICK_GAP: cfg_dclick_gap = data;
      REG_CLICK_TMO:  cfg_click_tmo  = data;
      REG_ADJUST_TMO: cfg_adjust_tmo = data;
      default: ;
    endcase
  endtask

  // Load all thresholds while idle; also poke the unused indexes, which must be ignored
  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] lp,
                                input logic [15:0] gap, input logic [15:0] ctmo,
                                input logic [15:0] atmo);
    drain_results();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_DCLICK_GAP, gap);
    write_reg(REG_CLICK_TMO, ctmo);
    write_reg(REG_ADJUST_TMO, atmo);
    for (int i = REG_ADJUST_TMO + 1; i < CFG_IDX_SPAN; i++)
      write_reg(3'(i), 16'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold one raw level for at least span ms, polling at random steps
  task automatic hold_level(input logic lvl, input int unsigned span,
                            input int unsigned step_max);
    int unsigned elapsed;
    int unsigned step;
    elapsed = 0;
    do begin
      step       = $urandom_range(step_max, 1);
      poll_clock = poll_clock + step;
      elapsed    = elapsed + step;
      send_poll(poll_clock, lvl);
    end while (elapsed < span);
  endtask

  // Contact bounce: random levels at short steps
  task automatic chatter(input int unsigned polls, input int unsigned step_max);
    repeat (polls) begin
      poll_clock = poll_clock + $urandom_range(step_max / 2 + 1, 1);
      send_poll(poll_clock, 1'($urandom));
    end
  endtask

  // One gesture with random timing around the current thresholds
  task automatic one_gesture(input int unsigned step_max);
    int unsigned deb, lp, gap, ctmo, atmo, kind;
    deb  = 32'(cfg_debounce);
    lp   = 32'(cfg_long_press);
    gap  = 32'(cfg_dclick_gap);
    ctmo = 32'(cfg_click_tmo);
    atmo = 32'(cfg_adjust_tmo);
    kind = $urandom_range(99);
    if (kind < 30) begin
      // single click, sometimes with bounce on the edges
      if ($urandom_range(3) == 0) chatter($urandom_range(5, 2), step_max);
      hold_level(1'b1, deb + $urandom_range(lp / 2 + 2, 1), step_max);
      if ($urandom_range(3) == 0) chatter($urandom_range(5, 2), step_max);
      hold_level(1'b0, deb + ctmo + $urandom_range(2 * step_max, 1), step_max);
    end else if (kind < 50) begin
      // double click, release gap on both sides of the limit
      hold_level(1'b1, deb + $urandom_range(lp / 2 + 2, 1), step_max);
      hold_level(1'b0, deb + $urandom_range(gap + step_max, 0), step_max);
      hold_level(1'b1, deb + $urandom_range(lp / 2 + 2, 1), step_max);
      hold_level(1'b0, deb + ctmo + $urandom_range(2 * step_max, 1), step_max);
    end else if (kind < 75) begin
      // long press, release into adjust, then leave adjust one of three ways
      hold_level(1'b1, deb + lp + $urandom_range(2 * step_max, 1), step_max);
      hold_level(1'b0, deb + $urandom_range(3 * step_max, 1), step_max);
      case ($urandom_range(2))
        0: hold_level(1'b0, atmo + $urandom_range(2 * step_max, 1), step_max);
        1: begin
          hold_level(1'b1, deb + $urandom_range(lp / 2 + 2, 1), step_max);
          hold_level(1'b0, deb + ctmo + $urandom_range(2 * step_max, 1), step_max);
        end
        default: begin
          hold_level(1'b1, deb + atmo + $urandom_range(2 * step_max, 1), step_max);
          hold_level(1'b0, deb + ctmo + $urandom_range(2 * step_max, 1), step_max);
        end
      endcase
    end else if (kind < 85) begin
      hold_level(1'b0, $urandom_range(deb + ctmo + step_max, 1), step_max);
    end else if (kind < 93) begin
      chatter($urandom_range(8, 2), step_max);
    end else begin
      // clock jump to anywhere in the 32-bit range
      poll_clock = $urandom;
      send_poll(poll_clock, 1'($urandom));
    end
  endtask

  task automatic run_gestures(input int unsigned polls, input int unsigned step_max);
    int unsigned target;
    target = polls_sent + polls;
    while (polls_sent < target) one_gesture(step_max);
  endtask

  // Reset thresholds: debounce edge, long press edge, press in adjust,
  // click timeout edge, double click, timestamp extremes
  task automatic test_directed_defaults();
    send_poll(32'd0, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'd10, 1'b1);
    send_poll(32'd60, 1'b1);
    send_poll(32'd61, 1'b1);
    send_poll(32'd1060, 1'b1);
    send_poll(32'd1061, 1'b1);
    send_poll(32'd1100, 1'b0);
    send_poll(32'd1151, 1'b0);
    send_poll(32'd1200, 1'b1);
    send_poll(32'd1251, 1'b1);
    send_poll(32'd1260, 1'b0);
    send_poll(32'd1311, 1'b0);
    send_poll(32'd1711, 1'b0);
    send_poll(32'd1712, 1'b0);
    send_poll(32'd2000, 1'b1);
    send_poll(32'd2051, 1'b1);
    send_poll(32'd2060, 1'b0);
    send_poll(32'd2111, 1'b0);
    send_poll(32'd2300, 1'b1);
    send_poll(32'd2351, 1'b1);
    send_poll(32'd2360, 1'b0);
    send_poll(32'd2411, 1'b0);
    send_poll(32'd2900, 1'b0);
    poll_clock = 32'd2900;
  endtask

  task automatic test_default_settings();
    run_gestures(120, 60);
  endtask

  task automatic test_short_settings();
    apply_settings(16'd3, 16'd40, 16'd15, 16'd20, 16'd80);
    run_gestures(250, 6);
  endtask

  task automatic test_zero_thresholds();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_gestures(150, 3);
  endtask

  task automatic test_max_thresholds();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_gestures(150, 9000);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      apply_settings(16'($urandom_range(60)), 16'($urandom_range(300)),
                     16'($urandom_range(120)), 16'($urandom_range(150)),
                     16'($urandom_range(400)));
      run_gestures(120, $urandom_range(20, 1));
    end
  endtask

  task automatic test_counter_wrap();
    apply_settings(16'd5, 16'd60, 16'd25, 16'd30, 16'd120);
    poll_clock = 32'hFFFF_FF00;
    run_gestures(120, 8);
  endtask

  task automatic test_no_idling();
    apply_settings(16'd2, 16'd30, 16'd10, 16'd12, 16'd50);
    quiet_run = 1'b1;
    run_gestures(150, 5);
    drain_results();
    quiet_run = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_DEBOUNCE;
    cfg_wdata_i     = '0;
    in_ch.valid     = 1'b0;
    in_ch.now_ms    = '0;
    in_ch.raw_level = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_default_settings();
    test_short_settings();
    test_zero_thresholds();
    test_max_thresholds();
    test_random_settings();
    test_counter_wrap();
    test_no_idling();
    drain_results();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
